/* hdl/aie_pkg.sv */
package aie_pkg;

    localparam int WORD_W    = 32;
    localparam int KIND_W    = 6;
    localparam int IMM_W     = 24;
    localparam int SHIFT_W   = 5;
    localparam int MEM_WORDS = 4096;
    localparam int ADDR_W    = $clog2(MEM_WORDS);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [KIND_W-1:0] kind_t;

    localparam word_t NEG_BIT = 32'h8000_0000;
    localparam word_t BIG_BIT = 32'h4000_0000;

    // instruction codes
    localparam kind_t OP_ADD      = 6'd0;
    localparam kind_t OP_SUB      = 6'd1;
    localparam kind_t OP_OR       = 6'd2;
    localparam kind_t OP_AND      = 6'd3;
    localparam kind_t OP_XOR      = 6'd4;
    localparam kind_t OP_NOT      = 6'd5;
    localparam kind_t OP_NEG      = 6'd6;
    localparam kind_t OP_SHL      = 6'd7;
    localparam kind_t OP_SHR      = 6'd8;
    localparam kind_t OP_ACC_IMM  = 6'd9;
    localparam kind_t OP_OPD_IMM  = 6'd10;
    localparam kind_t OP_REP_IMM  = 6'd11;
    localparam kind_t OP_SRC_IMM  = 6'd12;
    localparam kind_t OP_DST_IMM  = 6'd13;
    localparam kind_t OP_ACC_LD   = 6'd14;
    localparam kind_t OP_OPD_LD   = 6'd15;
    localparam kind_t OP_ACC_LDI  = 6'd16;
    localparam kind_t OP_OPD_LDI  = 6'd17;
    localparam kind_t OP_ST       = 6'd18;
    localparam kind_t OP_STI      = 6'd19;
    localparam kind_t OP_SRC_INC  = 6'd20;
    localparam kind_t OP_SRC_DEC  = 6'd21;
    localparam kind_t OP_DST_INC  = 6'd22;
    localparam kind_t OP_DST_DEC  = 6'd23;
    localparam kind_t OP_IMM      = 6'd24;
    localparam kind_t OP_OPD_ACC  = 6'd25;
    localparam kind_t OP_TMP_ACC  = 6'd26;
    localparam kind_t OP_REP_ACC  = 6'd27;
    localparam kind_t OP_SRC_ACC  = 6'd28;
    localparam kind_t OP_DST_ACC  = 6'd29;
    localparam kind_t OP_ACC_OPD  = 6'd30;
    localparam kind_t OP_ACC_TMP  = 6'd31;
    localparam kind_t OP_ACC_REP  = 6'd32;
    localparam kind_t OP_ACC_SRC  = 6'd33;
    localparam kind_t OP_ACC_DST  = 6'd34;
    localparam kind_t OP_NOP      = 6'd35;
    localparam kind_t OP_JZ       = 6'd36;
    localparam kind_t OP_JMN      = 6'd37;
    localparam kind_t OP_JNEG     = 6'd38;
    localparam kind_t OP_JBIG     = 6'd39;
    localparam kind_t OP_JMP      = 6'd40;
    localparam kind_t OP_REPEAT   = 6'd41;
    localparam kind_t OP_BRANCH   = 6'd42;
    localparam kind_t OP_MERGE    = 6'd43;

    typedef struct packed {
        word_t acc;
        logic  taken;
        word_t target;
    } res_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        word_t wdata;
        addr_t raddr;
    } mem_req_t;

endpackage

/* hdl/aie_ram.sv */
module aie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/aie_outq.sv */
module aie_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  aie_pkg::res_t   res_in,
    input  logic            stall,
    output logic            valid,
    output aie_pkg::res_t   res_out,
    output logic            skid_full
);

    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    aie_pkg::res_t out_reg, out_next;
    aie_pkg::res_t skid_reg, skid_next;
    logic          pop;

    assign pop = out_valid_reg & ~stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_next        = skid_reg;
                skid_valid_next = push;
                skid_next       = res_in;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_next = push;
            if (push)
            begin
                out_next = res_in;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign valid     = out_valid_reg;
    assign res_out   = out_reg;
    assign skid_full = skid_valid_reg;

endmodule

/* hdl/aie_core.sv */
module aie_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 instr_valid,
    output logic                 instr_stall,
    input  aie_pkg::kind_t       kind,
    input  logic [aie_pkg::IMM_W-1:0] immediate,
    input  aie_pkg::word_t       return_address,
    input  logic                 skid_full,
    output logic                 push,
    output aie_pkg::res_t        res,
    output aie_pkg::mem_req_t    mem_req,
    input  aie_pkg::word_t       mem_rdata
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_INDIR = 4'b0100,
        ST_LOAD  = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    aie_pkg::addr_t clr_addr_reg, clr_addr_next;
    aie_pkg::kind_t pend_reg, pend_next;

    aie_pkg::word_t acc_reg, acc_next;
    aie_pkg::word_t opd_reg, opd_next;
    aie_pkg::word_t link_reg, link_next;
    aie_pkg::word_t tmp_reg, tmp_next;
    aie_pkg::word_t rep_reg, rep_next;
    aie_pkg::word_t src_reg, src_next;
    aie_pkg::word_t dst_reg, dst_next;
    aie_pkg::word_t imm_reg, imm_next;

    logic           accept;
    logic           taken;
    aie_pkg::word_t rep_dec;

    assign instr_stall = (state_reg != ST_IDLE) | skid_full;
    assign accept      = instr_valid & ~instr_stall;
    assign rep_dec     = rep_reg - aie_pkg::word_t'(1);

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        pend_next     = pend_reg;
        acc_next      = acc_reg;
        opd_next      = opd_reg;
        link_next     = link_reg;
        tmp_next      = tmp_reg;
        rep_next      = rep_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        imm_next      = imm_reg;
        taken         = 1'b0;
        push          = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = dst_reg[aie_pkg::ADDR_W-1:0];
        mem_req.wdata = acc_reg;
        mem_req.raddr = src_reg[aie_pkg::ADDR_W-1:0];

        case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_addr_reg;
                mem_req.wdata = '0;
                clr_addr_next = clr_addr_reg + aie_pkg::addr_t'(1);
                if (clr_addr_reg == aie_pkg::addr_t'(aie_pkg::MEM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    push      = 1'b1;
                    pend_next = kind;
                    case (kind)
                        aie_pkg::OP_ADD:     acc_next = acc_reg + opd_reg;
                        aie_pkg::OP_SUB:     acc_next = acc_reg - opd_reg;
                        aie_pkg::OP_OR:      acc_next = acc_reg | opd_reg;
                        aie_pkg::OP_AND:     acc_next = acc_reg & opd_reg;
                        aie_pkg::OP_XOR:     acc_next = acc_reg ^ opd_reg;
                        aie_pkg::OP_NOT:     acc_next = ~acc_reg;
                        aie_pkg::OP_NEG:     acc_next = ~acc_reg + aie_pkg::word_t'(1);
                        aie_pkg::OP_SHL:     acc_next = acc_reg << opd_reg[aie_pkg::SHIFT_W-1:0];
                        aie_pkg::OP_SHR:     acc_next = acc_reg >> opd_reg[aie_pkg::SHIFT_W-1:0];
                        aie_pkg::OP_ACC_IMM: acc_next = imm_reg;
                        aie_pkg::OP_OPD_IMM: opd_next = imm_reg;
                        aie_pkg::OP_REP_IMM: rep_next = imm_reg;
                        aie_pkg::OP_SRC_IMM: src_next = imm_reg;
                        aie_pkg::OP_DST_IMM: dst_next = imm_reg;
                        aie_pkg::OP_ACC_LD, aie_pkg::OP_OPD_LD:
                        begin
                            push       = 1'b0;
                            state_next = ST_LOAD;
                        end
                        aie_pkg::OP_ACC_LDI, aie_pkg::OP_OPD_LDI:
                        begin
                            push       = 1'b0;
                            state_next = ST_INDIR;
                        end
                        aie_pkg::OP_ST:      mem_req.we = 1'b1;
                        aie_pkg::OP_STI:
                        begin
                            // first fetch the pointer word at dst
                            mem_req.raddr = dst_reg[aie_pkg::ADDR_W-1:0];
                            push          = 1'b0;
                            state_next    = ST_INDIR;
                        end
                        aie_pkg::OP_SRC_INC: src_next = src_reg + aie_pkg::word_t'(1);
                        aie_pkg::OP_SRC_DEC: src_next = src_reg - aie_pkg::word_t'(1);
                        aie_pkg::OP_DST_INC: dst_next = dst_reg + aie_pkg::word_t'(1);
                        aie_pkg::OP_DST_DEC: dst_next = dst_reg - aie_pkg::word_t'(1);
                        aie_pkg::OP_IMM:     imm_next = aie_pkg::word_t'(immediate);
                        aie_pkg::OP_OPD_ACC: opd_next = acc_reg;
                        aie_pkg::OP_TMP_ACC: tmp_next = acc_reg;
                        aie_pkg::OP_REP_ACC: rep_next = acc_reg;
                        aie_pkg::OP_SRC_ACC: src_next = acc_reg;
                        aie_pkg::OP_DST_ACC: dst_next = acc_reg;
                        aie_pkg::OP_ACC_OPD: acc_next = opd_reg;
                        aie_pkg::OP_ACC_TMP: acc_next = tmp_reg;
                        aie_pkg::OP_ACC_REP: acc_next = rep_reg;
                        aie_pkg::OP_ACC_SRC: acc_next = src_reg;
                        aie_pkg::OP_ACC_DST: acc_next = dst_reg;
                        aie_pkg::OP_NOP:     taken = 1'b0;
                        aie_pkg::OP_JZ:      taken = (acc_reg == '0);
                        aie_pkg::OP_JMN:     taken = (acc_reg == aie_pkg::NEG_BIT);
                        aie_pkg::OP_JNEG:    taken = |(acc_reg & aie_pkg::NEG_BIT);
                        aie_pkg::OP_JBIG:    taken = |(acc_reg & aie_pkg::BIG_BIT);
                        aie_pkg::OP_JMP:     taken = 1'b1;
                        aie_pkg::OP_REPEAT:
                        begin
                            rep_next = rep_dec;
                            taken    = (rep_dec != '0);
                        end
                        aie_pkg::OP_BRANCH:
                        begin
                            link_next = return_address;
                            taken     = 1'b1;
                        end
                        aie_pkg::OP_MERGE:   taken = 1'b1;
                        default:             taken = 1'b0;
                    endcase
                end
            end
            ST_INDIR:
            begin
                // read data is the pointer word
                if (pend_reg == aie_pkg::OP_STI)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = mem_rdata[aie_pkg::ADDR_W-1:0];
                    push          = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    mem_req.raddr = mem_rdata[aie_pkg::ADDR_W-1:0];
                    state_next    = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (pend_reg == aie_pkg::OP_ACC_LD || pend_reg == aie_pkg::OP_ACC_LDI)
                begin
                    acc_next = mem_rdata;
                end
                else
                begin
                    opd_next = mem_rdata;
                end
                push       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res.acc    = acc_next;
        res.taken  = taken;
        res.target = link_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            acc_reg      <= '0;
            opd_reg      <= '0;
            link_reg     <= '0;
            tmp_reg      <= '0;
            rep_reg      <= '0;
            src_reg      <= '0;
            dst_reg      <= '0;
            imm_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            acc_reg      <= acc_next;
            opd_reg      <= opd_next;
            link_reg     <= link_next;
            tmp_reg      <= tmp_next;
            rep_reg      <= rep_next;
            src_reg      <= src_next;
            dst_reg      <= dst_next;
            imm_reg      <= imm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

/* hdl/accumulator_isa_execute_unit.sv */
// Execute unit for a 32-bit accumulator machine: one instruction per input beat, one result
// beat per instruction (accumulator, jump decision, link register). Register and jump
// instructions issue back to back while the output buffer has room. Data memory accesses go
// through a single-port-read synchronous RAM with a registered read; a direct load passes
// through LOAD, an indirect store through INDIR, a double-indirect load through INDIR then
// LOAD, and a direct store stays in idle; the input is stalled while such an access is in
// flight. Memory addresses are the low 12 bits of the pointer. After reset a clearing pass
// zeroes all 4096 data memory words, during which instr_stall stays high. A two-entry output
// buffer lets new instructions enter while a result waits on result_stall.
module accumulator_isa_execute_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          instr_valid,
    output logic                          instr_stall,
    input  logic [aie_pkg::KIND_W-1:0]    kind,
    input  logic [aie_pkg::IMM_W-1:0]     immediate,
    input  logic [aie_pkg::WORD_W-1:0]    return_address,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [aie_pkg::WORD_W-1:0]    accumulator,
    output logic                          jump_taken,
    output logic [aie_pkg::WORD_W-1:0]    jump_target
);

    aie_pkg::mem_req_t mem_req;
    aie_pkg::word_t    mem_rdata;
    aie_pkg::res_t     res;
    aie_pkg::res_t     res_out;
    logic              push;
    logic              skid_full;

    aie_ram #(
        .WIDTH (aie_pkg::WORD_W),
        .DEPTH (aie_pkg::MEM_WORDS)
    ) u_data_mem (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    aie_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .instr_valid    (instr_valid),
        .instr_stall    (instr_stall),
        .kind           (kind),
        .immediate      (immediate),
        .return_address (return_address),
        .skid_full      (skid_full),
        .push           (push),
        .res            (res),
        .mem_req        (mem_req),
        .mem_rdata      (mem_rdata)
    );

    aie_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res_in    (res),
        .stall     (result_stall),
        .valid     (result_valid),
        .res_out   (res_out),
        .skid_full (skid_full)
    );

    assign accumulator = res_out.acc;
    assign jump_taken  = res_out.taken;
    assign jump_target = res_out.target;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam aie_pkg::kind_t OP_UNUSED_LO = 6'd44;
    localparam aie_pkg::kind_t OP_UNUSED_HI = 6'd63;
    localparam int    RAND_ITEMS   = 1450;
    localparam int    HOLD_CYCLES  = 60;
    localparam int    IDLE_PCT     = 24;

    typedef logic [aie_pkg::IMM_W-1:0] lit_t;

    typedef struct {
        aie_pkg::kind_t op;
        lit_t           lit;
        aie_pkg::word_t ret;
        bit             drain;
    } instr_beat_t;

    logic           clk;
    logic           rst_n;
    logic           instr_valid;
    logic           instr_stall;
    aie_pkg::kind_t kind;
    lit_t           immediate;
    aie_pkg::word_t return_address;
    logic           result_valid;
    logic           result_stall;
    aie_pkg::word_t accumulator;
    logic           jump_taken;
    aie_pkg::word_t jump_target;

    // architectural state of the machine as the checker sees it
    aie_pkg::word_t arch_acc;
    aie_pkg::word_t arch_opd;
    aie_pkg::word_t arch_link;
    aie_pkg::word_t arch_tmp;
    aie_pkg::word_t arch_rep;
    aie_pkg::word_t arch_src;
    aie_pkg::word_t arch_dst;
    aie_pkg::word_t arch_imm;
    aie_pkg::word_t arch_mem [aie_pkg::MEM_WORDS];

    instr_beat_t    pend_instrs[$];
    aie_pkg::res_t  pending_results[$];
    instr_beat_t    drv_beat;
    logic           instr_took;
    int             accepted_cnt;
    int             mismatch_cnt;
    int             hold_left;
    bit             hold_done;
    logic           quiet;

    accumulator_isa_execute_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .instr_valid    (instr_valid),
        .instr_stall    (instr_stall),
        .kind           (kind),
        .immediate      (immediate),
        .return_address (return_address),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .accumulator    (accumulator),
        .jump_taken     (jump_taken),
        .jump_target    (jump_target)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // long stretch where neither side idles
    assign quiet = (accepted_cnt >= 500) && (accepted_cnt < 800);

    function automatic aie_pkg::res_t execute_instr(aie_pkg::kind_t op, lit_t lit,
                                                    aie_pkg::word_t ret);
        aie_pkg::res_t  r;
        logic           taken;
        aie_pkg::word_t ptr;
        taken = 1'b0;
        case (op)
            aie_pkg::OP_ADD:     arch_acc = arch_acc + arch_opd;
            aie_pkg::OP_SUB:     arch_acc = arch_acc - arch_opd;
            aie_pkg::OP_OR:      arch_acc = arch_acc | arch_opd;
            aie_pkg::OP_AND:     arch_acc = arch_acc & arch_opd;
            aie_pkg::OP_XOR:     arch_acc = arch_acc ^ arch_opd;
            aie_pkg::OP_NOT:     arch_acc = ~arch_acc;
            aie_pkg::OP_NEG:     arch_acc = ~arch_acc + 32'd1;
            aie_pkg::OP_SHL:     arch_acc = arch_acc << arch_opd[aie_pkg::SHIFT_W-1:0];
            aie_pkg::OP_SHR:     arch_acc = arch_acc >> arch_opd[aie_pkg::SHIFT_W-1:0];
            aie_pkg::OP_ACC_IMM: arch_acc = arch_imm;
            aie_pkg::OP_OPD_IMM: arch_opd = arch_imm;
            aie_pkg::OP_REP_IMM: arch_rep = arch_imm;
            aie_pkg::OP_SRC_IMM: arch_src = arch_imm;
            aie_pkg::OP_DST_IMM: arch_dst = arch_imm;
            aie_pkg::OP_ACC_LD:  arch_acc = arch_mem[arch_src[aie_pkg::ADDR_W-1:0]];
            aie_pkg::OP_OPD_LD:  arch_opd = arch_mem[arch_src[aie_pkg::ADDR_W-1:0]];
            aie_pkg::OP_ACC_LDI:
            begin
                ptr = arch_mem[arch_src[aie_pkg::ADDR_W-1:0]];
                arch_acc = arch_mem[ptr[aie_pkg::ADDR_W-1:0]];
            end
            aie_pkg::OP_OPD_LDI:
            begin
                ptr = arch_mem[arch_src[aie_pkg::ADDR_W-1:0]];
                arch_opd = arch_mem[ptr[aie_pkg::ADDR_W-1:0]];
            end
            aie_pkg::OP_ST:      arch_mem[arch_dst[aie_pkg::ADDR_W-1:0]] = arch_acc;
            aie_pkg::OP_STI:
            begin
                ptr = arch_mem[arch_dst[aie_pkg::ADDR_W-1:0]];
                arch_mem[ptr[aie_pkg::ADDR_W-1:0]] = arch_acc;
            end
            aie_pkg::OP_SRC_INC: arch_src = arch_src + 32'd1;
            aie_pkg::OP_SRC_DEC: arch_src = arch_src - 32'd1;
            aie_pkg::OP_DST_INC: arch_dst = arch_dst + 32'd1;
            aie_pkg::OP_DST_DEC: arch_dst = arch_dst - 32'd1;
            aie_pkg::OP_IMM:     arch_imm = {{(aie_pkg::WORD_W-aie_pkg::IMM_W){1'b0}}, lit};
            aie_pkg::OP_OPD_ACC: arch_opd = arch_acc;
            aie_pkg::OP_TMP_ACC: arch_tmp = arch_acc;
            aie_pkg::OP_REP_ACC: arch_rep = arch_acc;
            aie_pkg::OP_SRC_ACC: arch_src = arch_acc;
            aie_pkg::OP_DST_ACC: arch_dst = arch_acc;
            aie_pkg::OP_ACC_OPD: arch_acc = arch_opd;
            aie_pkg::OP_ACC_TMP: arch_acc = arch_tmp;
            aie_pkg::OP_ACC_REP: arch_acc = arch_rep;
            aie_pkg::OP_ACC_SRC: arch_acc = arch_src;
            aie_pkg::OP_ACC_DST: arch_acc = arch_dst;
            aie_pkg::OP_JZ:      taken = (arch_acc == '0);
            aie_pkg::OP_JMN:     taken = (arch_acc == aie_pkg::NEG_BIT);
            aie_pkg::OP_JNEG:    taken = ((arch_acc & aie_pkg::NEG_BIT) != '0);
            aie_pkg::OP_JBIG:    taken = ((arch_acc & aie_pkg::BIG_BIT) != '0);
            aie_pkg::OP_JMP:     taken = 1'b1;
            aie_pkg::OP_REPEAT:
            begin
                arch_rep = arch_rep - 32'd1;
                taken = (arch_rep != '0);
            end
            aie_pkg::OP_BRANCH:
            begin
                arch_link = ret;
                taken = 1'b1;
            end
            aie_pkg::OP_MERGE:   taken = 1'b1;
            default:             taken = 1'b0;
        endcase
        r.acc    = arch_acc;
        r.taken  = taken;
        r.target = arch_link;
        return r;
    endfunction

    task automatic queue_instr(aie_pkg::kind_t op, lit_t lit, aie_pkg::word_t ret);
        instr_beat_t b;
        b.op    = op;
        b.lit   = lit;
        b.ret   = ret;
        b.drain = 1'b0;
        pend_instrs.push_back(b);
    endtask

    task automatic queue_op(aie_pkg::kind_t op);
        queue_instr(op, lit_t'($urandom()), $urandom());
    endtask

    task automatic queue_imm(lit_t lit);
        queue_instr(aie_pkg::OP_IMM, lit, $urandom());
    endtask

    // addresses half the time in a small window so stores and loads meet
    function automatic lit_t rand_addr();
        if ($urandom_range(0, 1) == 0)
            return lit_t'($urandom_range(0, 15));
        return lit_t'($urandom());
    endfunction

    task automatic queue_sequence();
        int n;
        case ($urandom_range(0, 9))
            0:
            begin
                queue_imm(lit_t'($urandom()));
                queue_op(aie_pkg::kind_t'($urandom_range(aie_pkg::OP_ACC_IMM,
                                                         aie_pkg::OP_DST_IMM)));
            end
            1:
            begin
                queue_imm(lit_t'($urandom()));
                queue_op(aie_pkg::OP_ACC_IMM);
                if ($urandom_range(0, 1) == 0)
                    queue_imm(lit_t'($urandom_range(0, 40)));
                else
                    queue_imm(lit_t'($urandom()));
                queue_op(aie_pkg::OP_OPD_IMM);
                queue_op(aie_pkg::kind_t'($urandom_range(aie_pkg::OP_ADD, aie_pkg::OP_SHR)));
                queue_op(aie_pkg::kind_t'($urandom_range(aie_pkg::OP_ADD, aie_pkg::OP_SHR)));
            end
            2:
            begin
                queue_imm(rand_addr());
                queue_op(aie_pkg::OP_DST_IMM);
                queue_op(aie_pkg::OP_ST);
                queue_op($urandom_range(0, 1) ? aie_pkg::OP_DST_INC : aie_pkg::OP_DST_DEC);
                queue_op(aie_pkg::OP_ST);
            end
            3:
            begin
                queue_imm(rand_addr());
                queue_op(aie_pkg::OP_SRC_IMM);
                queue_op(aie_pkg::kind_t'($urandom_range(aie_pkg::OP_ACC_LD,
                                                         aie_pkg::OP_OPD_LDI)));
                queue_op($urandom_range(0, 1) ? aie_pkg::OP_SRC_INC : aie_pkg::OP_SRC_DEC);
                queue_op(aie_pkg::kind_t'($urandom_range(aie_pkg::OP_ACC_LD,
                                                         aie_pkg::OP_OPD_LDI)));
            end
            4:
            begin
                queue_imm(rand_addr());
                queue_op(aie_pkg::OP_DST_IMM);
                queue_imm(rand_addr());
                queue_op(aie_pkg::OP_ACC_IMM);
                queue_op($urandom_range(0, 1) ? aie_pkg::OP_STI : aie_pkg::OP_ST);
            end
            5:
            begin
                n = $urandom_range(0, 4);
                queue_imm(lit_t'(n));
                queue_op(aie_pkg::OP_REP_IMM);
                repeat (n + 1) queue_op(aie_pkg::OP_REPEAT);
            end
            6:
            begin
                queue_op(aie_pkg::OP_BRANCH);
                queue_op(aie_pkg::kind_t'($urandom_range(aie_pkg::OP_OPD_ACC,
                                                         aie_pkg::OP_NOP)));
                queue_op(aie_pkg::OP_MERGE);
            end
            7:
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        queue_imm('0);
                        queue_op(aie_pkg::OP_ACC_IMM);
                    end
                    1:
                    begin
                        queue_imm(lit_t'(1));
                        queue_op(aie_pkg::OP_ACC_IMM);
                        queue_imm(lit_t'(31));
                        queue_op(aie_pkg::OP_OPD_IMM);
                        queue_op(aie_pkg::OP_SHL);
                    end
                    default: queue_op(aie_pkg::kind_t'($urandom_range(aie_pkg::OP_ACC_OPD,
                                                                      aie_pkg::OP_ACC_DST)));
                endcase
                queue_op(aie_pkg::kind_t'($urandom_range(aie_pkg::OP_JZ, aie_pkg::OP_MERGE)));
            end
            8: repeat (3) queue_op(aie_pkg::kind_t'($urandom_range(aie_pkg::OP_OPD_ACC,
                                                                   aie_pkg::OP_ACC_DST)));
            default: repeat (3) queue_op(aie_pkg::kind_t'($urandom_range(0, OP_UNUSED_HI)));
        endcase
    endtask

    // sender: next beat goes out once the previous one was taken
    always @(negedge clk)
    begin
        if (rst_n && (!instr_valid || instr_took))
        begin
            if (pend_instrs.size() != 0
                && !(pend_instrs[0].drain && pending_results.size() != 0)
                && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                drv_beat = pend_instrs.pop_front();
                kind           <= drv_beat.op;
                immediate      <= drv_beat.lit;
                return_address <= drv_beat.ret;
                instr_valid    <= 1'b1;
            end
            else
            begin
                instr_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (!hold_done && accepted_cnt >= 300)
        begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        aie_pkg::res_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatch_cnt = mismatch_cnt + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (accumulator !== want.acc)
                begin
                    $error("accumulator: expected %h, got %h", want.acc, accumulator);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                if (jump_taken !== want.taken)
                begin
                    $error("jump_taken: expected %b, got %b", want.taken, jump_taken);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                if (jump_target !== want.target)
                begin
                    $error("jump_target: expected %h, got %h", want.target, jump_target);
                    mismatch_cnt = mismatch_cnt + 1;
                end
            end
        end
        if (rst_n && instr_valid && !instr_stall)
        begin
            pending_results.push_back(execute_instr(kind, immediate, return_address));
            accepted_cnt <= accepted_cnt + 1;
        end
        instr_took <= rst_n && instr_valid && !instr_stall;
    end

    initial
    begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        instr_valid    = 1'b0;
        result_stall   = 1'b0;
        kind           = aie_pkg::OP_NOP;
        immediate      = '0;
        return_address = '0;
        instr_took     = 1'b0;
        accepted_cnt   = 0;
        mismatch_cnt   = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        arch_acc       = '0;
        arch_opd       = '0;
        arch_link      = '0;
        arch_tmp       = '0;
        arch_rep       = '0;
        arch_src       = '0;
        arch_dst       = '0;
        arch_imm       = '0;
        for (int i = 0; i < aie_pkg::MEM_WORDS; i++)
            arch_mem[i] = '0;

        // directed: widest immediate, most negative value, wraps, repeat from zero
        queue_imm('1);
        queue_op(aie_pkg::OP_ACC_IMM);
        queue_op(aie_pkg::OP_OPD_IMM);
        queue_op(aie_pkg::OP_SHL);
        queue_op(aie_pkg::OP_JMN);
        queue_op(aie_pkg::OP_JNEG);
        queue_op(aie_pkg::OP_NEG);
        queue_op(aie_pkg::OP_ADD);
        queue_op(aie_pkg::OP_NOT);
        queue_op(aie_pkg::OP_JBIG);
        queue_op(aie_pkg::OP_REPEAT);
        queue_op(aie_pkg::OP_ACC_REP);
        queue_op(aie_pkg::OP_ADD);
        queue_op(aie_pkg::OP_SUB);
        queue_instr(aie_pkg::OP_BRANCH, '0, '1);
        queue_op(aie_pkg::OP_MERGE);
        queue_op(OP_UNUSED_LO);
        queue_op(OP_UNUSED_HI);
        queue_imm('0);
        queue_op(aie_pkg::OP_ACC_IMM);
        queue_op(aie_pkg::OP_JZ);
        queue_op(aie_pkg::OP_SHR);
        queue_op(aie_pkg::OP_ST);
        queue_instr(aie_pkg::OP_BRANCH, '0, '0);
        queue_op(aie_pkg::OP_ACC_LDI);

        while (pend_instrs.size() < RAND_ITEMS)
            queue_sequence();
        // sender waits for the pipe to drain at these points
        pend_instrs[900].drain  = 1'b1;
        pend_instrs[1300].drain = 1'b1;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pend_instrs.size() != 0 || instr_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
